// File: sv/mec_pkg.sv
// Shared types, constants and saturating helpers for the Mandelbrot escape block.
`default_nettype none

package mec_pkg;

  localparam int C_W     = 32;   // point coordinate width on the input beat
  localparam int LIMIT_W = 16;   // iteration limit register width
  localparam int OUT_W   = 16;   // color and count width on the result beat
  localparam int Z_W     = 64;   // orbit value width
  localparam int QUO_W   = 8;    // quotient bits of the color scale divide

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 16'd2;

  localparam logic signed [Z_W-1:0] INT64_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] INT64_MIN = {1'b1, {(Z_W-1){1'b0}}};

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_TEST = 7'b0000010,
    ST_MAG  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_SAT  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  // Which square or cross product the shared multiplier is working on
  typedef enum logic [1:0] {
    SEL_RR = 2'd0,
    SEL_II = 2'd1,
    SEL_RI = 2'd2
  } prod_sel_t;

  function automatic logic signed [Z_W-1:0] sat_add64(input logic signed [Z_W-1:0] a,
                                                      input logic signed [Z_W-1:0] b);
    logic signed [Z_W-1:0] s;
    s = a + b;
    if ((a[Z_W-1] == b[Z_W-1]) && (s[Z_W-1] != a[Z_W-1])) begin
      return a[Z_W-1] ? INT64_MIN : INT64_MAX;
    end
    return s;
  endfunction

  function automatic logic [Z_W-1:0] mag64(input logic signed [Z_W-1:0] v);
    logic [Z_W-1:0] u;
    u = v;
    return v[Z_W-1] ? (~u + 64'd1) : u;
  endfunction

endpackage

`default_nettype wire

// File: sv/mec_if.sv
// Valid/ready stream interfaces for the point beat and the result beat.
`default_nettype none

interface mec_in_if import mec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [C_W-1:0] c_real;
  logic signed [C_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mec_out_if import mec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] color_value;
  logic [OUT_W-1:0] escape_count;

  modport source (output valid, output color_value, output escape_count, input ready);
  modport sink   (input valid, input color_value, input escape_count, output ready);
endinterface

`default_nettype wire

// File: sv/mandelbrot_escape_color.sv
// Top level: escape-time coloring of one Mandelbrot point on a shared 32x32 multiplier.
`default_nettype none
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  in_ch    | in  | valid/ready        | c_real, c_imag  (signed Q4.28, 32 b each)
//  out_ch   | out | valid/ready        | color_value, escape_count (16 b each)
//  cfg      | in  | cfg_we, no wait    | cfg_wdata = iteration_limit (16 b)
//
//  One iteration of z = z*z + c runs the test/add state, the magnitude
//  state, then three 64x64 products, each as four 32x32 partials through
//  the one multiplier plus a saturate state. The restoring color divide
//  follows the loop when the point escapes. in_ch.ready is high only in
//  idle; the result register lets a new beat in while a result waits.
//  Reset (synchronous) sets the limit to 256 and empties the result register.

module mandelbrot_escape_color import mec_pkg::*; #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  mec_in_if.sink             in_ch,
  mec_out_if.source          out_ch
);

  localparam int CW = COUNT_BITS + 1;   // step count, holds limit + 1
  localparam int NW = COUNT_BITS + 8;   // 254 * n
  localparam logic [Z_W-1:0] BOUND = 64'd4 << FRAC_BITS;
  localparam logic [2:0] PP_LAST = 3'd4;   // cycle that folds in the last partial

  state_t state_r, state_nxt;

  logic [LIMIT_W-1:0]    limit_r;
  logic [COUNT_BITS-1:0] lim_r;
  logic [CW-1:0]         k_r;

  logic signed [Z_W-1:0] cr_r, ci_r;
  logic signed [Z_W-1:0] zr_r, zi_r;
  logic signed [Z_W-1:0] zr2_r, zi2_r, zri_r;
  logic [Z_W-1:0]        mzr_r, mzi_r;
  logic                  nzr_r, nzi_r;

  prod_sel_t        sel_r;
  logic [2:0]       pp_r;
  logic [1:0]       pcode_r;
  logic [Z_W-1:0]   prod_r;
  logic [2*Z_W-1:0] acc_r;

  logic [NW-1:0]         rem_r;
  logic [COUNT_BITS-1:0] div_r;
  logic [QUO_W-1:0]      q_r;
  logic [2:0]            dcnt_r;
  logic                  noesc_r;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] color_r, count_r;

  // effective limit: register value clamped to the counter range
  logic [32:0]           lim_wide, lim_cap, lim_sel;
  logic [COUNT_BITS-1:0] lim_eff;

  assign lim_wide = 33'(limit_r);
  assign lim_cap  = (33'd1 << COUNT_BITS) - 33'd1;
  assign lim_sel  = (lim_wide > lim_cap) ? lim_cap : lim_wide;
  assign lim_eff  = lim_sel[COUNT_BITS-1:0];

  logic in_acc, out_load;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.color_value  = color_r;
  assign out_ch.escape_count = count_r;

  // loop test and next z from the previous products
  logic [Z_W-1:0]        esc_sum;
  logic                  run;
  logic signed [Z_W-1:0] zr_calc, zi_calc;
  logic [CW-1:0]         n_val;

  assign esc_sum = zr2_r + zi2_r;   // both non-negative, no overflow
  assign run     = (esc_sum < BOUND) && (k_r <= {1'b0, lim_r});
  assign zr_calc = sat_add64(sat_add64(zr2_r, -zi2_r), cr_r);
  assign zi_calc = sat_add64(sat_add64(zri_r, zri_r), ci_r);
  assign n_val   = k_r - CW'(1);

  // shared multiplier: pp 0..3 = x0*y0, x0*y1, x1*y0, x1*y1
  logic [Z_W-1:0]   mul_a, mul_b;
  logic [31:0]      a_half, b_half;
  logic [Z_W-1:0]   partial;
  logic [6:0]       shamt;
  logic [2*Z_W-1:0] acc_inc;

  assign mul_a   = (sel_r == SEL_II) ? mzi_r : mzr_r;
  assign mul_b   = (sel_r == SEL_RR) ? mzr_r : mzi_r;
  assign a_half  = pp_r[1] ? mul_a[63:32] : mul_a[31:0];
  assign b_half  = pp_r[0] ? mul_b[63:32] : mul_b[31:0];
  assign partial = a_half * b_half;
  assign shamt   = {pcode_r[1] & pcode_r[0], pcode_r[1] ^ pcode_r[0], 5'b0};
  assign acc_inc = 128'(prod_r) << shamt;

  // product >> FRAC_BITS, magnitude saturated at 2^63-1, sign reapplied
  logic [2*Z_W-1:0]      acc_sh;
  logic [Z_W-2:0]        sat_mag;
  logic                  sat_neg;
  logic signed [Z_W-1:0] sat_res;

  assign acc_sh  = acc_r >> FRAC_BITS;
  assign sat_mag = (|acc_sh[2*Z_W-1:Z_W-1]) ? {(Z_W-1){1'b1}} : acc_sh[Z_W-2:0];
  assign sat_neg = (sel_r == SEL_RI) && (nzr_r ^ nzi_r);
  assign sat_res = sat_neg ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});

  // color scale: 254*n by shifts, then one quotient bit per cycle
  logic [COUNT_BITS-1:0] n_lo;
  logic [NW-1:0]         num_init, trial;

  assign n_lo     = n_val[COUNT_BITS-1:0];
  assign num_init = (NW'(n_lo) << 8) - (NW'(n_lo) << 1);
  assign trial    = NW'(div_r) << dcnt_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_TEST;
      ST_TEST: begin
        if (run) begin
          state_nxt = ST_MAG;
        end else if (n_val >= {1'b0, lim_r}) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_MAG:  state_nxt = ST_MUL;
      ST_MUL:  if (pp_r == PP_LAST) state_nxt = ST_SAT;
      ST_SAT:  state_nxt = (sel_r == SEL_RI) ? ST_TEST : ST_MUL;
      ST_DIV:  if (dcnt_r == 3'd0) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= (cfg_wdata < LIMIT_MIN) ? LIMIT_MIN : cfg_wdata;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cr_r  <= {{(Z_W-C_W){in_ch.c_real[C_W-1]}}, in_ch.c_real};
          ci_r  <= {{(Z_W-C_W){in_ch.c_imag[C_W-1]}}, in_ch.c_imag};
          zr2_r <= '0;
          zi2_r <= '0;
          zri_r <= '0;
          k_r   <= '0;
          lim_r <= lim_eff;
        end
      end
      ST_TEST: begin
        if (run) begin
          zr_r <= zr_calc;
          zi_r <= zi_calc;
          k_r  <= k_r + CW'(1);
        end else begin
          noesc_r <= (n_val >= {1'b0, lim_r});
          rem_r   <= num_init;
          div_r   <= lim_r - COUNT_BITS'(1);
          q_r     <= '0;
          dcnt_r  <= 3'(QUO_W - 1);
        end
      end
      ST_MAG: begin
        mzr_r <= mag64(zr_r);
        mzi_r <= mag64(zi_r);
        nzr_r <= zr_r[Z_W-1];
        nzi_r <= zi_r[Z_W-1];
        sel_r <= SEL_RR;
        pp_r  <= '0;
        acc_r <= '0;
      end
      ST_MUL: begin
        if (pp_r != PP_LAST) begin
          prod_r  <= partial;
          pcode_r <= pp_r[1:0];
        end
        if (pp_r != 3'd0) begin
          acc_r <= acc_r + acc_inc;
        end
        pp_r <= pp_r + 3'd1;
      end
      ST_SAT: begin
        case (sel_r)
          SEL_RR:  zr2_r <= sat_res;
          SEL_II:  zi2_r <= sat_res;
          default: zri_r <= sat_res;
        endcase
        sel_r <= (sel_r == SEL_RR) ? SEL_II : SEL_RI;
        pp_r  <= '0;
        acc_r <= '0;
      end
      ST_DIV: begin
        if (rem_r >= trial) begin
          rem_r       <= rem_r - trial;
          q_r[dcnt_r] <= 1'b1;
        end
        dcnt_r <= dcnt_r - 3'd1;
      end
      ST_DONE: begin
        if (out_load) begin
          color_r <= noesc_r ? OUT_W'(lim_r) : (OUT_W'(q_r) + OUT_W'(1));
          count_r <= OUT_W'(n_val);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/mec_checker.sv
// Port-level checker for the Mandelbrot escape block, with its bind.
`default_nettype none

module mec_checker import mec_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] color_value,
  input logic [OUT_W-1:0] escape_count
);

  // one point at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a point is in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(color_value) && $stable(escape_count))
    else $error("result changed while stalled");

  a_color_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> color_value != '0)
    else $error("zero color");

  // colors above 255 only come from points that ran to the limit
  a_limit_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (color_value > 16'd255) |-> color_value == escape_count)
    else $error("large color does not match limit count");

endmodule

bind mandelbrot_escape_color mec_checker u_mec_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .color_value  (out_ch.color_value),
  .escape_count (out_ch.escape_count)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the Mandelbrot escape-time color block.
`timescale 1ns / 100ps

module tb_top;
  import mec_pkg::*;

  // Q4.28 on the point beat; the block is built with its default FRAC_BITS.
  localparam int FRAC_Q = 28;
  localparam int ONE_Q = 1 << FRAC_Q;
  localparam int C_026 = 69793219;            // 0.26: just right of the cusp, escapes slowly
  localparam int MAX_C = 32'h7FFF_FFFF;
  localparam int MIN_C = 32'h8000_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;
  localparam logic [Z_W-1:0] ESC_BOUND = 64'd4 << FRAC_Q;   // |z|^2 >= 4 means escaped
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 60;            // covers color divide plus a stalled result
  localparam longint TIMEOUT_NS = 50_000_000;

  typedef struct packed {
    logic [C_W-1:0] re;
    logic [C_W-1:0] im;
  } point_t;

  typedef struct packed {
    logic [OUT_W-1:0] color;
    logic [OUT_W-1:0] count;
    logic [C_W-1:0]   re;
    logic [C_W-1:0]   im;
  } escape_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  mec_in_if  pt_ch ();
  mec_out_if res_ch ();

  mandelbrot_escape_color dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (pt_ch),
    .out_ch    (res_ch)
  );

  point_t             point_queue[$];   // points waiting to be driven
  escape_t            escape_due[$];    // predicted results, oldest first
  logic [LIMIT_W-1:0] limit_now;        // effective limit as the block should hold it
  int unsigned        sent_cnt, taken_cnt, result_cnt, escaped_cnt;
  int unsigned        gap_left, stall_left, err_cnt, setting_cnt;
  bit                 gaps_on;          // off gives back-to-back stretches on both sides
  point_t             nxt;
  escape_t            fresh, due;

  // ---------------------------------------------------------------------------
  // Predictor: saturating 64-bit orbit arithmetic, exact 128-bit products.
  // ---------------------------------------------------------------------------

  function automatic logic signed [Z_W-1:0] clip_add(input logic signed [Z_W-1:0] a,
                                                     input logic signed [Z_W-1:0] b);
    logic signed [Z_W:0] s;
    s = a + b;
    if (s[Z_W] != s[Z_W-1]) return s[Z_W] ? INT64_MIN : INT64_MAX;
    return s[Z_W-1:0];
  endfunction

  // (a*b) >> FRAC on magnitudes, so the shift rounds toward zero; magnitude clips
  // at 2^63-1 and the sign is put back afterwards.
  function automatic logic signed [Z_W-1:0] qmul(input logic signed [Z_W-1:0] a,
                                                 input logic signed [Z_W-1:0] b);
    logic [Z_W-1:0]   ua, ub, m;
    logic [2*Z_W-1:0] prod;
    ua = a[Z_W-1] ? -a : a;
    ub = b[Z_W-1] ? -b : b;
    prod = {{Z_W{1'b0}}, ua} * {{Z_W{1'b0}}, ub};
    prod = prod >> FRAC_Q;
    if (prod[2*Z_W-1:Z_W-1] != '0) m = INT64_MAX;
    else m = prod[Z_W-1:0];
    return (a[Z_W-1] ^ b[Z_W-1]) ? -m : m;
  endfunction

  // Iterate z = z*z + c from zero. The step count starts at zero, and the count
  // reported is one less than the iterations done.
  function automatic escape_t predict_escape(input point_t p, input logic [LIMIT_W-1:0] lim);
    logic signed [Z_W-1:0] cr, ci, zr, zi, rr, ii, ri;
    logic [Z_W-1:0]        mag2;
    int unsigned           steps, n, col;
    escape_t               e;
    cr = $signed(p.re);
    ci = $signed(p.im);
    rr = '0;
    ii = '0;
    ri = '0;
    mag2 = '0;
    steps = 0;
    while (mag2 < ESC_BOUND && steps <= lim) begin
      zr = clip_add(clip_add(rr, -ii), cr);
      zi = clip_add(clip_add(ri, ri), ci);
      rr = qmul(zr, zr);
      ii = qmul(zi, zi);
      ri = qmul(zr, zi);
      mag2 = rr + ii;               // both non-negative, cannot wrap
      steps++;
    end
    n = steps - 1;
    col = (n >= lim) ? lim : 254 * n / (lim - 1) + 1;
    e.color = col[OUT_W-1:0];
    e.count = n[OUT_W-1:0];
    e.re = p.re;
    e.im = p.im;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Mix of raw 32-bit noise (mostly instant escapes), the interesting window
  // around the set, the inner core (mostly held to the limit) and thin strips
  // near the cusp and the neck where escape is slow.
  function automatic point_t random_point();
    point_t      p;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      p.re = $urandom;
      p.im = $urandom;
    end else if (r < 75) begin
      p.re = span(-2 * ONE_Q - ONE_Q / 4, 3 * ONE_Q / 4);
      p.im = span(-3 * ONE_Q / 2, 3 * ONE_Q / 2);
    end else if (r < 90) begin
      p.re = span(-ONE_Q / 2, ONE_Q / 4);
      p.im = span(-ONE_Q / 2, ONE_Q / 2);
    end else begin
      p.re = $urandom_range(0, 1) ? ONE_Q / 4 + span(0, ONE_Q / 16)
                                  : -3 * ONE_Q / 4 + span(-ONE_Q / 64, ONE_Q / 64);
      p.im = span(-ONE_Q / 64, ONE_Q / 64);
    end
    return p;
  endfunction

  task automatic push_pt(input int re, input int im);
    point_t p;
    p.re = re;
    p.im = im;
    point_queue.push_back(p);
  endtask

  // Block is idle once every driven point has been taken and answered.
  task automatic wait_idle();
    while (point_queue.size() != 0 || sent_cnt != taken_cnt || escape_due.size() != 0)
      @(posedge clk);
  endtask

  // Limit writes only happen with the block idle; 0 and 1 clamp to 2.
  task automatic apply_limit(input logic [LIMIT_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= LIMIT_W'($urandom);   // junk while the enable is low
    limit_now = (v < LIMIT_MIN) ? LIMIT_MIN : v;
    setting_cnt++;
  endtask

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Point driver: changes on the falling edge. A beat stays up until the
  // sampler has counted it taken, then an optional gap follows.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      pt_ch.valid <= 1'b0;
    end else if (sent_cnt != taken_cnt) begin
      // beat still waiting for ready: hold everything
    end else if (gap_left != 0) begin
      pt_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (point_queue.size() != 0) begin
      nxt = point_queue.pop_front();
      pt_ch.c_real <= nxt.re;
      pt_ch.c_imag <= nxt.im;
      pt_ch.valid <= 1'b1;
      sent_cnt++;
      gap_left <= pick_gap();
    end else begin
      pt_ch.valid <= 1'b0;
    end
  end

  // Result ready: one cycle high, then a random stall, which may be zero.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Point sampler: every accepted beat gets its prediction with the limit
  // in force at that moment (limit only moves while idle).
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && pt_ch.valid && pt_ch.ready) begin
      fresh = predict_escape(point_t'({pt_ch.c_real, pt_ch.c_imag}), limit_now);
      if (fresh.count < limit_now) escaped_cnt++;
      escape_due.push_back(fresh);
      taken_cnt++;
    end
  end

  // Result checker: in-order compare against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      result_cnt++;
      if (escape_due.size() == 0) begin
        flag_error($sformatf("unexpected result color=%0d count=%0d",
                             res_ch.color_value, res_ch.escape_count));
      end else begin
        due = escape_due.pop_front();
        if (res_ch.color_value !== due.color)
          flag_error($sformatf("c=(%0d,%0d) limit %0d: color exp %0d got %0d",
                               $signed(due.re), $signed(due.im), limit_now,
                               due.color, res_ch.color_value));
        if (res_ch.escape_count !== due.count)
          flag_error($sformatf("c=(%0d,%0d) limit %0d: count exp %0d got %0d",
                               $signed(due.re), $signed(due.im), limit_now,
                               due.count, res_ch.escape_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------

  initial begin
    int     ph;
    point_t far_pt;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    pt_ch.valid = 1'b0;
    pt_ch.c_real = '0;
    pt_ch.c_imag = '0;
    res_ch.ready = 1'b0;
    limit_now = LIMIT_RESET;
    gaps_on = 1'b1;
    setting_cnt = 1;
    sent_cnt = 0;
    taken_cnt = 0;
    result_cnt = 0;
    escaped_cnt = 0;
    gap_left = 0;
    stall_left = 0;
    err_cnt = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points at the reset limit: field extremes, points inside the
    // set (origin, -1, cusp, i, just inside -2, real -1.5, LSB-sized c),
    // points exactly on the |z| = 2 boundary, and slow or fast escapes.
    push_pt(MAX_C, MAX_C);
    push_pt(MIN_C, MIN_C);
    push_pt(MAX_C, MIN_C);
    push_pt(MIN_C, MAX_C);
    push_pt(0, 0);
    push_pt(-ONE_Q, 0);
    push_pt(ONE_Q / 4, 0);
    push_pt(0, ONE_Q);
    push_pt(-2 * ONE_Q, 0);
    push_pt(-2 * ONE_Q + 1, 0);
    push_pt(0, -2 * ONE_Q);
    push_pt(C_026, 0);
    push_pt(ONE_Q / 2, 0);
    push_pt(-3 * ONE_Q / 4, ONE_Q / 10);
    push_pt(ONE_Q, ONE_Q);
    push_pt(1, -1);
    push_pt(-1, -1);
    push_pt(-ONE_Q / 2, ONE_Q / 2);
    push_pt(-3 * ONE_Q / 2, 0);
    push_pt(ONE_Q / 3, ONE_Q / 2);

    // Writes of 0 and 1 both clamp to the minimum limit.
    apply_limit(16'd0);
    repeat (30) point_queue.push_back(random_point());
    apply_limit(16'd1);
    repeat (20) point_queue.push_back(random_point());

    // Top limit: only points known to escape, or the run would take forever.
    apply_limit(LIMIT_TOP);
    push_pt(C_026, 0);
    push_pt(3 * ONE_Q / 10, 0);
    push_pt(ONE_Q / 2, ONE_Q / 2);
    push_pt(-3 * ONE_Q / 4, ONE_Q / 10);
    push_pt(-3 * ONE_Q / 4, ONE_Q / 100);   // neck, a few hundred steps
    push_pt(MAX_C, MAX_C);
    repeat (14) begin
      far_pt.re = $urandom;
      far_pt.im = $urandom;
      // push |re| to 2 or more so the first step escapes
      if (far_pt.re[31:29] == 3'b000 || far_pt.re[31:29] == 3'b111)
        far_pt.re[30] = ~far_pt.re[30];
      point_queue.push_back(far_pt);
    end

    apply_limit(16'd3);
    repeat (100) point_queue.push_back(random_point());

    // Bulk of the run: small random limits keep non-escaping points cheap.
    for (ph = 0; ph < 11; ph++) begin
      apply_limit(16'($urandom_range(4, 32)));
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (100) point_queue.push_back(random_point());
    end

    apply_limit(16'd100);
    gaps_on = 1'b1;
    repeat (30) point_queue.push_back(random_point());

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d points over %0d limit settings (2 to %0d).",
             result_cnt, taken_cnt, setting_cnt, LIMIT_TOP);
    $display("%0d points escaped, %0d ran to the limit, %0d mismatches.",
             escaped_cnt, taken_cnt - escaped_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d points taken, %0d results still due", taken_cnt, escape_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
